// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk, except while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property at every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/ssd_pkg.sv =====
// Types and constants of the streaming substring detector.
package ssd_pkg;

  // Width of one pattern or text character.
  localparam int unsigned CHAR_W = 8;

  // Item kinds carried in the operation field.
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic              pat_shift;   // shift a pattern character into the chain
    logic              text_step;   // compare a text character in every cell
    logic              text_clear;  // drop all partial matches
    logic [CHAR_W-1:0] ch;          // character of the current transfer
  } ssd_ctrl_t;

endpackage

// ===== hw/rtl/ssd_in_if.sv =====
// Input channel interface: one pattern or text character per transfer.
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output operation, output character, output last,
                  input ready);
  modport sink   (input valid, input operation, input character, input last,
                  output ready);
endinterface

// ===== hw/rtl/ssd_out_if.sv =====
// Result channel interface: the outcome of one complete text.
interface ssd_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pattern_overflow;

  modport source (output valid, output found, output pattern_overflow, input ready);
  modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

// ===== hw/rtl/streaming_substring_detector.sv =====
// Top level of the streaming substring detector: control, cell chain and result register.
//
//   channel  | role  | payload                       | moves
//   ---------+-------+-------------------------------+------------------------------
//   item     | sink  | operation, character, last    | one character per transfer
//   result   | source| found, pattern_overflow       | one per text ending in last
//
// A new item is taken in every cycle while item.ready is high: each cell
// compares the broadcast text character with its own pattern character and hands its
// partial-match bit to its left neighbour, so the rate is set by one cell's compare.
// A result appears in the output register in the cycle after the last text character.
// Reset (rst, synchronous) empties the pattern and clears all text state.
// Input is held off only while an undelivered result sits in the output register.
`include "assert_macros.svh"

module streaming_substring_detector import ssd_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 128
) (
  input logic     clk,
  input logic     rst,
  ssd_in_if.sink  item,
  ssd_out_if.source result
);

  logic                    xfer;
  logic                    is_pat;
  logic                    pat_start;
  logic                    pat_full;
  logic                    found_now;
  ssd_ctrl_t               ctrl;

  logic                    pat_complete;
  logic                    overflow_mark;
  logic                    match_seen;
  logic                    res_valid;
  logic                    res_found;
  logic                    res_ovf;

  logic [CHAR_W-1:0]       cell_char [MAX_PATTERN];
  logic [CHAR_W-1:0]       char_link [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]  cell_valid;
  logic [MAX_PATTERN-1:0]  valid_link;
  logic [MAX_PATTERN-1:0]  cell_d;
  logic [MAX_PATTERN-1:0]  cell_hit;

  // Handshake: the output register frees up when its result is taken.
  assign item.ready = !res_valid || result.ready;
  assign xfer       = item.valid && item.ready;

  // Decode the transfer into chain control.
  assign is_pat          = xfer && (item.operation == OP_PATTERN);
  assign pat_start       = is_pat && pat_complete;
  assign pat_full        = cell_valid[MAX_PATTERN-1];
  assign ctrl.pat_shift  = is_pat && (pat_start || !pat_full);
  assign ctrl.text_step  = xfer && (item.operation == OP_TEXT);
  assign ctrl.text_clear = pat_start || (ctrl.text_step && item.last);
  assign ctrl.ch         = item.character;

  // The cell at the head holds the final pattern character, so its hit is a full match.
  assign found_now = match_seen || (cell_hit[0] && cell_valid[0]);

  // Chain of cells; a new pattern enters at the head and empties the rest.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign char_link[j]  = ctrl.ch;
      assign valid_link[j] = 1'b1;
    end else begin : g_body
      assign char_link[j]  = cell_char[j-1];
      assign valid_link[j] = cell_valid[j-1] && !pat_start;
    end

    if (j == MAX_PATTERN - 1) begin : g_tail
      ssd_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .char_left   (char_link[j]),
        .valid_left  (valid_link[j]),
        .d_right     (1'b0),
        .valid_right (1'b0),
        .pat_char    (cell_char[j]),
        .valid       (cell_valid[j]),
        .d           (cell_d[j]),
        .hit         (cell_hit[j])
      );
    end else begin : g_inner
      ssd_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .char_left   (char_link[j]),
        .valid_left  (valid_link[j]),
        .d_right     (cell_d[j+1]),
        .valid_right (cell_valid[j+1]),
        .pat_char    (cell_char[j]),
        .valid       (cell_valid[j]),
        .d           (cell_d[j]),
        .hit         (cell_hit[j])
      );
    end
  end

  // Pattern and text status flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_complete  <= 1'b1;
      overflow_mark <= 1'b0;
      match_seen    <= 1'b0;
    end else begin
      if (is_pat) begin
        pat_complete <= item.last;
      end else if (ctrl.text_step) begin
        pat_complete <= 1'b1;
      end

      if (pat_start) begin
        overflow_mark <= 1'b0;
      end else if (is_pat && pat_full) begin
        overflow_mark <= 1'b1;
      end

      if (ctrl.text_clear) begin
        match_seen <= 1'b0;
      end else if (ctrl.text_step && cell_hit[0] && cell_valid[0]) begin
        match_seen <= 1'b1;
      end
    end
  end

  // Output register: loaded on the last text character, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.text_step && item.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.text_step && item.last) begin
      res_found <= found_now;
      res_ovf   <= overflow_mark;
    end
  end

  assign result.valid            = res_valid;
  assign result.found            = res_found;
  assign result.pattern_overflow = res_ovf;

  // The last text character of a transfer always leaves a result behind.
  `ASSERT_CLK(a_result_follows_last,
    xfer && (item.operation == OP_TEXT) && item.last |=> res_valid,
    "No result after the last text character.")
  // An empty pattern never reports a match.
  `ASSERT_CLK(a_found_needs_pattern,
    res_valid && res_found |-> cell_valid[0],
    "Match reported with an empty pattern.")
  // Characters are only dropped once the chain is full.
  `ASSERT_ALWAYS(a_overflow_needs_full,
    overflow_mark |-> cell_valid[MAX_PATTERN-1],
    "Overflow marked while the chain still has room.")

endmodule

// ===== hw/rtl/ssd_cell.sv =====
// One cell of the matching chain: a pattern character and a partial-match bit.
module ssd_cell import ssd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ssd_ctrl_t         ctrl,
  input  logic [CHAR_W-1:0] char_left,
  input  logic              valid_left,
  input  logic              d_right,
  input  logic              valid_right,
  output logic [CHAR_W-1:0] pat_char,
  output logic              valid,
  output logic              d,
  output logic              hit
);

  logic d_link;

  // A cell whose right neighbour holds no pattern character starts a match.
  assign d_link = valid_right ? d_right : 1'b1;
  assign hit    = d_link && (ctrl.ch == pat_char);

  // Pattern characters move one cell along on each pattern transfer the chain accepts.
  always_ff @(posedge clk) begin
    if (ctrl.pat_shift) begin
      pat_char <= char_left;
    end
  end

  // Occupancy and partial-match state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      d     <= 1'b0;
    end else begin
      if (ctrl.pat_shift) begin
        valid <= valid_left;
      end
      if (ctrl.text_clear) begin
        d <= 1'b0;
      end else if (ctrl.text_step) begin
        d <= hit;
      end
    end
  end

endmodule
